/* rtl/framebuffer_alpha_blit_top_macros.svh */
// ----------------------------------------------------------------------------
// framebuffer alpha blitter assertion macros
// shared concurrent assertion forms, clocked on i_clk, idle while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_ALPHA_BLIT_TOP_MACROS_SVH
`define FRAMEBUFFER_ALPHA_BLIT_TOP_MACROS_SVH

// same-cycle implication
`define FAB_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fab assertion failed");

// next-cycle implication
`define FAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fab assertion failed");

`endif

/* rtl/fab_pkg.sv */
// ----------------------------------------------------------------------------
// fab_pkg
// shared sizes, codes and control types of the framebuffer alpha blitter
// ----------------------------------------------------------------------------
package fab_pkg;

    // framebuffer geometry
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(FB_DEPTH);
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int CRD_W      = ((DIM_W > 9) ? DIM_W : 9) + 2;

    // field widths
    localparam int PIX_W     = 32;
    localparam int POS_W     = 8;
    localparam int DIM_REG_W = 8;
    localparam int OFS_W     = 9;
    localparam int OPA_W     = 8;
    localparam int ALPHA_W   = 8;
    localparam int REQ_W     = 2;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 5;

    // blend constants
    localparam logic [PIX_W-1:0]   RB_MASK      = 32'h00ff00ff;
    localparam logic [PIX_W-1:0]   G_MASK       = 32'h0000ff00;
    localparam logic [PIX_W-1:0]   RB_ROUND     = 32'h00800080;
    localparam logic [PIX_W-1:0]   G_ROUND      = 32'h00008000;
    localparam logic [PIX_W-1:0]   ALPHA_OPAQUE = 32'h000000ff;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL   = 8'hff;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_BLIT  = 2'd2
    } t_req;

    // register indexes
    typedef enum logic [2:0] {
        REG_FB_WIDTH    = 3'd0,
        REG_FB_HEIGHT   = 3'd1,
        REG_SRC_WIDTH   = 3'd2,
        REG_SRC_HEIGHT  = 3'd3,
        REG_OFFSET_X    = 3'd4,
        REG_OFFSET_Y    = 3'd5,
        REG_OPACITY     = 3'd6,
        REG_BLEND_MODE  = 3'd7
    } t_reg;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_RD,
        S_MIX,
        S_WB,
        S_DONE
    } t_state;

    // configuration registers
    typedef struct packed {
        logic [DIM_REG_W-1:0]    fb_width;
        logic [DIM_REG_W-1:0]    fb_height;
        logic [DIM_REG_W-1:0]    src_width;
        logic [DIM_REG_W-1:0]    src_height;
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
        logic [OPA_W-1:0]        opacity;
        logic                    blend_mode;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic capture;
        logic calc;
        logic mem_rd;
        logic mix;
        logic mem_wr;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic need_read;
        logic need_write;
        logic blend;
    } t_stat;

endpackage

/* rtl/framebuffer_alpha_blit_top.sv */
// ----------------------------------------------------------------------------
// framebuffer_alpha_blit_top
// an accepted word runs calc then done if it touches no pixel; a write or copy adds
// write-back, a read adds read and mix, a blend adds read, mix and write-back; result
// valid is registered from the load in done; one word at a time: the next word is taken
// in idle after the result is loaded; a stalled result holds the block in its last step
// reset: synchronous; a clearing pass zeroes every framebuffer word, no words taken
// ----------------------------------------------------------------------------
module framebuffer_alpha_blit_top
    import fab_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // source side
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [47:0]        i_s_axis_tdata,   // pos_x, pos_y, pixel_color
    input  logic [REQ_W-1:0]   i_s_axis_tuser,   // req_type
    // result side
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [39:0]        o_m_axis_tdata,   // read_data, pixel_written, zero pad
    output logic               o_m_axis_tlast,   // blit_last
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;
    t_reg  reg_idx;
    logic  pixel_written;
    logic [PIX_W-1:0] read_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg'(paddr[PADDR_W-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fb_width   <= DIM_REG_W'(MAX_WIDTH);
            r_cfg.fb_height  <= DIM_REG_W'(MAX_HEIGHT);
            r_cfg.src_width  <= '0;
            r_cfg.src_height <= '0;
            r_cfg.offset_x   <= '0;
            r_cfg.offset_y   <= '0;
            r_cfg.opacity    <= '1;
            r_cfg.blend_mode <= 1'b1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FB_WIDTH:   r_cfg.fb_width   <= pwdata[DIM_REG_W-1:0];
                REG_FB_HEIGHT:  r_cfg.fb_height  <= pwdata[DIM_REG_W-1:0];
                REG_SRC_WIDTH:  r_cfg.src_width  <= pwdata[DIM_REG_W-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= pwdata[DIM_REG_W-1:0];
                REG_OFFSET_X:   r_cfg.offset_x   <= $signed(pwdata[OFS_W-1:0]);
                REG_OFFSET_Y:   r_cfg.offset_y   <= $signed(pwdata[OFS_W-1:0]);
                REG_OPACITY:    r_cfg.opacity    <= pwdata[OPA_W-1:0];
                REG_BLEND_MODE: r_cfg.blend_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_FB_WIDTH:   prdata = APB_DW'(r_cfg.fb_width);
            REG_FB_HEIGHT:  prdata = APB_DW'(r_cfg.fb_height);
            REG_SRC_WIDTH:  prdata = APB_DW'(r_cfg.src_width);
            REG_SRC_HEIGHT: prdata = APB_DW'(r_cfg.src_height);
            REG_OFFSET_X:   prdata = APB_DW'(unsigned'(r_cfg.offset_x));
            REG_OFFSET_Y:   prdata = APB_DW'(unsigned'(r_cfg.offset_y));
            REG_OPACITY:    prdata = APB_DW'(r_cfg.opacity);
            REG_BLEND_MODE: prdata = APB_DW'(r_cfg.blend_mode);
            default:        prdata = '0;
        endcase
    end

    fab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fab_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_restart       (cfg_wr),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_s_axis_tuser),
        .i_pos_x         (i_s_axis_tdata[7:0]),
        .i_pos_y         (i_s_axis_tdata[15:8]),
        .i_pixel_color   (i_s_axis_tdata[47:16]),
        .o_read_data     (read_data),
        .o_pixel_written (pixel_written),
        .o_blit_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'b0, pixel_written, read_data};

endmodule

/* rtl/fab_ram.sv */
// ----------------------------------------------------------------------------
// fab_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module fab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per cycle, write or read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fab_datapath.sv */
// ----------------------------------------------------------------------------
// fab_datapath
// address generation, source walk, alpha blend and framebuffer access
// ----------------------------------------------------------------------------
module fab_datapath
    import fab_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_restart,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    input  logic [PIX_W-1:0]   i_pixel_color,
    output logic [PIX_W-1:0]   o_read_data,
    output logic               o_pixel_written,
    output logic               o_blit_last
);

    // saturate a size register to the storage limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v,
                                                   input int lim);
        logic [DIM_W-1:0] res;
        if (int'(v) > lim) begin
            res = DIM_W'(lim);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // captured item
    logic [REQ_W-1:0] r_req;
    logic [POS_W-1:0] r_px;
    logic [POS_W-1:0] r_py;
    logic [PIX_W-1:0] r_color;

    // source walk position
    logic [DIM_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;
    logic [DIM_W-1:0] n_col;
    logic [DIM_W-1:0] n_row;

    // per-item decisions
    logic [ADDR_W-1:0]  r_addr;
    logic               r_blend;
    logic               r_is_read;
    logic               r_wr;
    logic               r_last;
    logic [ALPHA_W:0]   r_a1;
    logic [PIX_W-1:0]   r_rdata;

    // blend products
    logic [PIX_W-1:0] r_prb;
    logic [PIX_W-1:0] r_pg;
    logic [PIX_W-1:0] r_drb;
    logic [PIX_W-1:0] r_dg;

    // clearing pass
    logic [ADDR_W-1:0] r_clr_cnt;

    // result word
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_wr;
    logic             r_out_last;

    logic [DIM_W-1:0]         dw;
    logic [DIM_W-1:0]         dh;
    logic [DIM_W-1:0]         sw;
    logic [DIM_W-1:0]         sh;
    logic                     blit_on;
    logic [DIM_W-1:0]         col_use;
    logic [DIM_W-1:0]         row_use;
    logic [DIM_W-1:0]         col_inc;
    logic [DIM_W-1:0]         row_inc;
    logic                     walk_end;
    logic signed [CRD_W-1:0]  cx;
    logic signed [CRD_W-1:0]  cy;
    logic                     in_range;
    logic [2*DIM_W-1:0]       row_base;
    logic [ADDR_W-1:0]        addr;
    logic [2*ALPHA_W-1:0]     a_prod;
    logic [ALPHA_W-1:0]       a_val;
    logic                     wr_plain;
    logic                     do_mix;
    logic                     is_read;
    logic                     is_blit;
    logic [PIX_W-1:0]         ram_rdata;
    logic [PIX_W-1:0]         src_s;
    logic [PIX_W-1:0]         dst_d;
    logic [PIX_W-1:0]         drb;
    logic [PIX_W-1:0]         dg;
    logic [PIX_W-1:0]         diff_rb;
    logic [PIX_W-1:0]         diff_g;
    logic [PIX_W-1:0]         mix_rb;
    logic [PIX_W-1:0]         mix_g;
    logic [PIX_W-1:0]         mix_px;
    logic                     ram_en;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [PIX_W-1:0]         ram_wdata;

    // sizes in use
    assign dw = clamp_dim(i_cfg.fb_width, MAX_WIDTH);
    assign dh = clamp_dim(i_cfg.fb_height, MAX_HEIGHT);
    assign sw = clamp_dim(i_cfg.src_width, MAX_WIDTH);
    assign sh = clamp_dim(i_cfg.src_height, MAX_HEIGHT);
    assign blit_on = (sw != '0) && (sh != '0);
    assign is_blit = (r_req == REQ_BLIT);

    // source walk step
    always_comb begin
        col_use  = (r_col >= sw) ? '0 : r_col;
        row_use  = (r_row >= sh) ? '0 : r_row;
        col_inc  = col_use + 1'b1;
        row_inc  = row_use + 1'b1;
        walk_end = 1'b0;
        n_col    = col_inc;
        n_row    = row_use;
        if (col_inc >= sw) begin
            n_col = '0;
            n_row = row_inc;
            if (row_inc >= sh) begin
                n_row    = '0;
                walk_end = 1'b1;
            end
        end
    end

    // destination coordinate
    always_comb begin
        if (is_blit) begin
            cx = $signed({{(CRD_W-OFS_W){i_cfg.offset_x[OFS_W-1]}}, i_cfg.offset_x})
               + $signed({{(CRD_W-DIM_W){1'b0}}, col_use});
            cy = $signed({{(CRD_W-OFS_W){i_cfg.offset_y[OFS_W-1]}}, i_cfg.offset_y})
               + $signed({{(CRD_W-DIM_W){1'b0}}, row_use});
        end else begin
            cx = $signed({{(CRD_W-POS_W){1'b0}}, r_px});
            cy = $signed({{(CRD_W-POS_W){1'b0}}, r_py});
        end
    end

    // range check and linear address
    assign in_range = !cx[CRD_W-1] && !cy[CRD_W-1]
                   && (cx[CRD_W-2:0] < {{(CRD_W-1-DIM_W){1'b0}}, dw})
                   && (cy[CRD_W-2:0] < {{(CRD_W-1-DIM_W){1'b0}}, dh});
    assign row_base = cy[DIM_W-1:0] * dw;
    assign addr     = ADDR_W'(cx[DIM_W-1:0]) + ADDR_W'(row_base);

    // scaled source alpha
    assign a_prod = r_color[ALPHA_W-1:0] * i_cfg.opacity;
    assign a_val  = a_prod[2*ALPHA_W-1:ALPHA_W];

    // what this item does to the framebuffer
    always_comb begin
        wr_plain = 1'b0;
        do_mix   = 1'b0;
        is_read  = 1'b0;
        case (r_req)
            REQ_WRITE: wr_plain = in_range;
            REQ_READ:  is_read  = in_range;
            REQ_BLIT: begin
                if (blit_on && in_range) begin
                    if (!i_cfg.blend_mode || (a_val == ALPHA_FULL)) begin
                        wr_plain = 1'b1;
                    end else if (a_val != '0) begin
                        do_mix = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_stat.clr_last   = (r_clr_cnt == ADDR_W'(FB_DEPTH - 1));
    assign o_stat.need_read  = is_read || do_mix;
    assign o_stat.need_write = wr_plain;
    assign o_stat.blend      = r_blend;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req_type;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_color <= i_pixel_color;
        end
    end

    // source position, restarted by any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.calc && is_blit && blit_on) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // per-item decisions
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_addr    <= addr;
            r_blend   <= do_mix;
            r_is_read <= is_read;
            r_wr      <= wr_plain || do_mix;
            r_last    <= is_blit && blit_on && walk_end;
            r_a1      <= {1'b0, a_val} + 1'b1;
        end
    end

    // read word
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_rdata <= '0;
        end else if (i_cmd.mix && r_is_read) begin
            r_rdata <= ram_rdata;
        end
    end

    // blend multiply stage
    assign src_s   = {8'b0, r_color[PIX_W-1:8]};
    assign dst_d   = {8'b0, ram_rdata[PIX_W-1:8]};
    assign drb     = dst_d & RB_MASK;
    assign dg      = dst_d & G_MASK;
    assign diff_rb = (src_s & RB_MASK) - drb;
    assign diff_g  = (src_s & G_MASK) - dg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_prb <= diff_rb * PIX_W'(r_a1);
            r_pg  <= diff_g * PIX_W'(r_a1);
            r_drb <= drb;
            r_dg  <= dg;
        end
    end

    // blend add stage
    assign mix_rb = r_drb + ((r_prb + RB_ROUND) >> 8);
    assign mix_g  = r_dg + ((r_pg + G_ROUND) >> 8);
    assign mix_px = (((mix_rb & RB_MASK) + (mix_g & G_MASK)) << 8) | ALPHA_OPAQUE;

    // framebuffer port
    always_comb begin
        ram_en    = i_cmd.clr || i_cmd.mem_rd || i_cmd.mem_wr;
        ram_we    = i_cmd.clr || i_cmd.mem_wr;
        ram_addr  = i_cmd.clr ? r_clr_cnt : r_addr;
        ram_wdata = i_cmd.clr ? '0 : (r_blend ? mix_px : r_color);
    end

    fab_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FB_DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_rdata;
            r_out_wr   <= r_wr;
            r_out_last <= r_last;
        end
    end

    assign o_read_data     = r_out_data;
    assign o_pixel_written = r_out_wr;
    assign o_blit_last     = r_out_last;

endmodule

/* rtl/fab_ctrl.sv */
// ----------------------------------------------------------------------------
// fab_ctrl
// sequencer for clearing, per-word steps and the result handshake
// ----------------------------------------------------------------------------
`include "framebuffer_alpha_blit_top_macros.svh"

module fab_ctrl
    import fab_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_CALC;
            end
            S_CALC: begin
                if (i_stat.need_read) begin
                    n_state = S_RD;
                end else if (i_stat.need_write) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD:  n_state = S_MIX;
            S_MIX: n_state = i_stat.blend ? S_WB : S_DONE;
            S_WB:  n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr      = (r_state == S_CLEAR);
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.mem_rd   = (r_state == S_RD);
        o_cmd.mix      = (r_state == S_MIX);
        o_cmd.mem_wr   = (r_state == S_WB);
        o_cmd.out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `FAB_ASSERT_NEXT(a_accept_to_calc, (r_state == S_IDLE) && i_in_valid, r_state == S_CALC)
    `FAB_ASSERT_IMPLY(a_load_when_free, o_cmd.out_load, !r_out_valid || i_out_ready)
    `FAB_ASSERT_IMPLY(a_clear_complete, (r_state == S_IDLE) && ($past(r_state) == S_CLEAR), $past(i_stat.clr_last))
    `FAB_ASSERT_IMPLY(a_wb_origin, r_state == S_WB, ($past(r_state) == S_CALC) || ($past(r_state) == S_MIX))

endmodule
